// ===== hw/rtl/kslp_pkg.sv =====
// Package: payload types, key codes and register indexes for the key scanner.
`timescale 1ns / 1ps

package kslp_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned IntW     = 8;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned KeyW     = 3;
  localparam int unsigned LenW     = 8;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS      = 2'd1;

  localparam logic [IntW-1:0]  SampleIntervalRst = 8'd20;
  localparam logic [HoldW-1:0] LongPressRst      = 16'd1000;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_TAKE = 2'd1;
  localparam logic [1:0] ACT_MENU = 2'd2;

  localparam logic [KeyW-1:0] KEY_NONE = 3'd0;
  localparam logic [KeyW-1:0] KEY_UP   = 3'd1;
  localparam logic [KeyW-1:0] KEY_DOWN = 3'd2;
  localparam logic [KeyW-1:0] KEY_OK   = 3'd3;
  localparam logic [KeyW-1:0] KEY_LONG = 3'd4;

  typedef struct packed {
    logic [1:0]      action;
    logic            up_level;
    logic            down_level;
    logic            ok_level;
    logic [LenW-1:0] menu_length;
  } req_t;

  typedef struct packed {
    logic [KeyW-1:0] key_code;
    logic [LenW-1:0] menu_value;
  } rsp_t;

  typedef struct packed {
    logic                en;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

// ===== hw/rtl/kslp_if.sv =====
// Interfaces: request, result and register write channels.
`timescale 1ns / 1ps

interface kslp_req_if ();
  logic            valid;
  logic            ready;
  kslp_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kslp_rsp_if ();
  logic            valid;
  logic            ready;
  kslp_pkg::rsp_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kslp_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [kslp_pkg::CfgIdxW-1:0]      index;
  logic [kslp_pkg::CfgDataW-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/key_scan_long_press_menu_cursor.sv =====
// Top level: key scanner with long press, release latch and menu cursor.
// Channels: req_i carries one request per handshake (tick with pin levels,
// take of the latched key, or menu cursor step with the menu length);
// rsp_o returns exactly one result per request, in order; cfg_i writes
// register 0 (sample interval) or 1 (long press threshold), always ready.
// Timing: an accepted request waits in the input register until the result
// register can load; the core then processes it and its result is held
// valid on rsp_o until the receiver takes it.
// Throughput: one request per cycle while rsp_o is not stalled, set by the
// input register feeding the core's state update and the result register.
// Reset: all counters, codes and the latched key clear, the cursor goes to
// 1, and the registers return to interval 20 and threshold 1000.
// Stall: while rsp_o waits, the input register still takes one request;
// further requests wait until the result is taken. Nothing is dropped.
`timescale 1ns / 1ps

module key_scan_long_press_menu_cursor (
  input  logic        clk_i,
  input  logic        rst_ni,
  kslp_req_if.sink    req_i,
  kslp_rsp_if.source  rsp_o,
  kslp_cfg_if.sink    cfg_i
);

  logic              s1_valid;
  kslp_pkg::req_t    s1_data;
  logic              adv;
  kslp_pkg::rsp_t    core_rsp;
  kslp_pkg::cfg_wr_t cfg_wr;
  logic              go;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr.en   = cfg_i.valid;
  assign cfg_wr.idx  = cfg_i.index;
  assign cfg_wr.data = cfg_i.data;

  assign go = s1_valid && adv;

  kslp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_i.valid),
    .data_i  (req_i.data),
    .ready_o (req_i.ready),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  kslp_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .req_i  (s1_data),
    .cfg_i  (cfg_wr),
    .rsp_o  (core_rsp)
  );

  kslp_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .data_i  (core_rsp),
    .adv_o   (adv),
    .valid_o (rsp_o.valid),
    .data_o  (rsp_o.data),
    .ready_i (rsp_o.ready)
  );

endmodule

// ===== hw/rtl/kslp_in_stage.sv =====
// Input register: holds one request until the core consumes it.
`timescale 1ns / 1ps

module kslp_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  kslp_pkg::req_t data_i,
  output logic           ready_o,
  input  logic           adv_i,
  output logic           valid_o,
  output kslp_pkg::req_t data_o
);

  logic           valid_q, valid_d;
  kslp_pkg::req_t data_q;
  logic           take;

  assign ready_o = !valid_q || adv_i;
  assign take    = valid_i && ready_o;
  assign valid_d = take ? 1'b1 : (adv_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== hw/rtl/kslp_core.sv =====
// Core: hold counter, sample divider, key encoder, release latch and menu cursor.
`timescale 1ns / 1ps

module kslp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              go_i,
  input  kslp_pkg::req_t    req_i,
  input  kslp_pkg::cfg_wr_t cfg_i,
  output kslp_pkg::rsp_t    rsp_o
);

  logic [kslp_pkg::IntW-1:0]  interval_q, interval_d;
  logic [kslp_pkg::HoldW-1:0] long_q, long_d;
  logic [kslp_pkg::IntW-1:0]  div_q, div_d, div_inc;
  logic [kslp_pkg::HoldW-1:0] hold_q, hold_d;
  logic [kslp_pkg::KeyW-1:0]  prior_q, prior_d;
  logic [kslp_pkg::KeyW-1:0]  cur_q, cur_d;
  logic [kslp_pkg::KeyW-1:0]  latch_q, latch_d;
  logic [kslp_pkg::LenW-1:0]  cursor_q, cursor_d;
  logic [kslp_pkg::LenW-1:0]  len;
  logic [kslp_pkg::HoldW-1:0] hold_next;
  logic [kslp_pkg::KeyW-1:0]  code;

  always_comb begin
    interval_d = interval_q;
    long_d     = long_q;
    if (cfg_i.en) begin
      case (cfg_i.idx)
        kslp_pkg::CFG_SAMPLE_INTERVAL: interval_d = cfg_i.data[kslp_pkg::IntW-1:0];
        kslp_pkg::CFG_LONG_PRESS:      long_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign len = (req_i.menu_length == '0) ? kslp_pkg::LenW'(1) : req_i.menu_length;

  // hold counter saturates while ok is held
  assign hold_next = req_i.ok_level ? '0 :
                     ((hold_q == '1) ? hold_q : hold_q + kslp_pkg::HoldW'(1));
  assign div_inc   = div_q + kslp_pkg::IntW'(1);

  always_comb begin
    if (!req_i.up_level) begin
      code = kslp_pkg::KEY_UP;
    end else if (!req_i.down_level) begin
      code = kslp_pkg::KEY_DOWN;
    end else if (!req_i.ok_level && (hold_next > long_q)) begin
      code = kslp_pkg::KEY_LONG;
    end else if (!req_i.ok_level) begin
      code = kslp_pkg::KEY_OK;
    end else begin
      code = kslp_pkg::KEY_NONE;
    end
  end

  always_comb begin
    div_d    = div_q;
    hold_d   = hold_q;
    prior_d  = prior_q;
    cur_d    = cur_q;
    latch_d  = latch_q;
    cursor_d = cursor_q;
    rsp_o.key_code   = kslp_pkg::KEY_NONE;
    rsp_o.menu_value = '0;
    if (go_i) begin
      case (req_i.action)
        kslp_pkg::ACT_TICK: begin
          hold_d = hold_next;
          div_d  = div_inc;
          if (div_inc >= interval_q) begin
            div_d   = '0;
            prior_d = cur_q;
            cur_d   = code;
            if ((cur_q != kslp_pkg::KEY_NONE) && (code == kslp_pkg::KEY_NONE)) begin
              latch_d = cur_q;
            end
          end
        end
        kslp_pkg::ACT_TAKE: begin
          rsp_o.key_code = latch_q;
          latch_d        = kslp_pkg::KEY_NONE;
        end
        kslp_pkg::ACT_MENU: begin
          rsp_o.key_code = latch_q;
          latch_d        = kslp_pkg::KEY_NONE;
          case (latch_q)
            kslp_pkg::KEY_UP: begin
              cursor_d = (cursor_q <= kslp_pkg::LenW'(1)) ? len
                                                          : cursor_q - kslp_pkg::LenW'(1);
              rsp_o.menu_value = cursor_d;
            end
            kslp_pkg::KEY_DOWN: begin
              cursor_d = (cursor_q >= len) ? kslp_pkg::LenW'(1)
                                           : cursor_q + kslp_pkg::LenW'(1);
              rsp_o.menu_value = cursor_d;
            end
            kslp_pkg::KEY_OK: begin
              cursor_d = kslp_pkg::LenW'(1);
              rsp_o.menu_value = '0;
            end
            default: begin
              rsp_o.menu_value = cursor_q;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= kslp_pkg::SampleIntervalRst;
      long_q     <= kslp_pkg::LongPressRst;
      div_q      <= '0;
      hold_q     <= '0;
      prior_q    <= kslp_pkg::KEY_NONE;
      cur_q      <= kslp_pkg::KEY_NONE;
      latch_q    <= kslp_pkg::KEY_NONE;
      cursor_q   <= kslp_pkg::LenW'(1);
    end else begin
      interval_q <= interval_d;
      long_q     <= long_d;
      div_q      <= div_d;
      hold_q     <= hold_d;
      prior_q    <= prior_d;
      cur_q      <= cur_d;
      latch_q    <= latch_d;
      cursor_q   <= cursor_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_cursor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q != '0) else $error("cursor left the 1..length range");

  a_latch_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q <= kslp_pkg::KEY_LONG) else $error("latched key out of code range");

  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && ((req_i.action == kslp_pkg::ACT_TAKE) || (req_i.action == kslp_pkg::ACT_MENU))
    |=> latch_q == kslp_pkg::KEY_NONE) else $error("take did not clear latched key");

  a_hold_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && (req_i.action == kslp_pkg::ACT_TICK) && req_i.ok_level |=> hold_q == '0)
    else $error("hold counter not cleared on release");
`endif

endmodule

// ===== hw/rtl/kslp_out_reg.sv =====
// Result register: holds one result until the receiver takes it.
`timescale 1ns / 1ps

module kslp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  kslp_pkg::rsp_t data_i,
  output logic           adv_o,
  output logic           valid_o,
  output kslp_pkg::rsp_t data_o,
  input  logic           ready_i
);

  logic           valid_q, valid_d;
  kslp_pkg::rsp_t data_q;
  logic           load;

  assign adv_o   = !valid_q || ready_i;
  assign load    = valid_i && adv_o;
  assign valid_d = load ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== tb/key_scan_long_press_menu_cursor_tb.sv =====
// Testbench: key scanner driven by directed and gesture-shaped random requests, checked per field.
`timescale 1ns / 1ps

module key_scan_long_press_menu_cursor_tb;

  localparam logic [1:0] ActUnused = 2'd3;
  localparam logic [kslp_pkg::CfgIdxW-1:0] CfgIdxSpareA = 2'd2;
  localparam logic [kslp_pkg::CfgIdxW-1:0] CfgIdxSpareB = 2'd3;
  localparam int ResetRows = 4;
  localparam int DirCount = 25;

  typedef struct packed {
    logic [1:0]                act;
    logic                      up;
    logic                      dn;
    logic                      ok;
    logic [kslp_pkg::LenW-1:0] len;
    logic                      fixed;
    logic [kslp_pkg::KeyW-1:0] key;
    logic [kslp_pkg::LenW-1:0] val;
  } dir_row_t;

  // rows before ResetRows run with the reset register values
  localparam dir_row_t DirRows [DirCount] = '{
    '{kslp_pkg::ACT_TAKE, 1'b1, 1'b1, 1'b1, 8'd5,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b1, 1'b1, 1'b1, 8'd5,   1'b1, kslp_pkg::KEY_NONE, 8'd1},
    '{ActUnused,          1'b0, 1'b0, 1'b0, 8'd255, 1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd0,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b0, 1'b1, 1'b1, 8'd7,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd7,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b1, 1'b1, 1'b1, 8'd5,   1'b0, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b0, 1'b1, 8'd3,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd3,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b1, 1'b1, 1'b1, 8'd5,   1'b0, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b0, 1'b1, 8'd9,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd9,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b1, 1'b1, 1'b1, 8'd0,   1'b0, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b0, 8'd1,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b0, 8'd1,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b0, 8'd1,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd1,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b0, 1'b0, 1'b0, 8'd255, 1'b0, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b0, 8'd2,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd2,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_MENU, 1'b1, 1'b1, 1'b1, 8'd255, 1'b0, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b0, 1'b0, 1'b0, 8'd4,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TICK, 1'b1, 1'b1, 1'b1, 8'd4,   1'b1, kslp_pkg::KEY_NONE, 8'd0},
    '{kslp_pkg::ACT_TAKE, 1'b1, 1'b1, 1'b1, 8'd4,   1'b1, kslp_pkg::KEY_UP,   8'd0},
    '{kslp_pkg::ACT_TAKE, 1'b1, 1'b1, 1'b1, 8'd4,   1'b1, kslp_pkg::KEY_NONE, 8'd0}
  };

  logic clk_i;
  logic rst_ni;

  kslp_req_if req_if ();
  kslp_rsp_if rsp_if ();
  kslp_cfg_if cfg_if ();

  key_scan_long_press_menu_cursor u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // scanner state mirrored by the predictor
  logic [kslp_pkg::IntW-1:0]  pr_interval;
  logic [kslp_pkg::HoldW-1:0] pr_long;
  logic [kslp_pkg::IntW-1:0]  pr_div;
  logic [kslp_pkg::HoldW-1:0] pr_hold;
  logic [kslp_pkg::KeyW-1:0]  pr_prior;
  logic [kslp_pkg::KeyW-1:0]  pr_code;
  logic [kslp_pkg::KeyW-1:0]  pr_latched;
  logic [kslp_pkg::LenW-1:0]  pr_cursor;

  kslp_pkg::rsp_t awaited_rsp[$];
  int   mismatches = 0;
  int   sent = 0;
  int   settings = 0;
  int   long_keys = 0;
  int   menu_steps = 0;
  int   req_gap_pct = 29;
  int   rsp_stall_pct = 29;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd50_000_000);
    $display("Mismatches found");
    $finish;
  end

  function automatic kslp_pkg::rsp_t predict_scan(input kslp_pkg::req_t r);
    logic [kslp_pkg::LenW-1:0] len;
    logic [kslp_pkg::KeyW-1:0] code;
    kslp_pkg::rsp_t o;
    len = (r.menu_length == '0) ? 8'd1 : r.menu_length;
    o = '0;
    case (r.action)
      kslp_pkg::ACT_TICK: begin
        if (!r.ok_level) begin
          if (pr_hold != '1) pr_hold = pr_hold + 16'd1;
        end else begin
          pr_hold = '0;
        end
        pr_div = pr_div + 8'd1;
        if (pr_div >= pr_interval) begin
          pr_div = '0;
          pr_prior = pr_code;
          if (!r.up_level) code = kslp_pkg::KEY_UP;
          else if (!r.down_level) code = kslp_pkg::KEY_DOWN;
          else if (!r.ok_level && pr_hold > pr_long) code = kslp_pkg::KEY_LONG;
          else if (!r.ok_level) code = kslp_pkg::KEY_OK;
          else code = kslp_pkg::KEY_NONE;
          pr_code = code;
          if (pr_prior != kslp_pkg::KEY_NONE && pr_code == kslp_pkg::KEY_NONE)
            pr_latched = pr_prior;
        end
      end
      kslp_pkg::ACT_TAKE: begin
        o.key_code = pr_latched;
        pr_latched = kslp_pkg::KEY_NONE;
      end
      kslp_pkg::ACT_MENU: begin
        o.key_code = pr_latched;
        pr_latched = kslp_pkg::KEY_NONE;
        menu_steps++;
        case (o.key_code)
          kslp_pkg::KEY_UP: begin
            pr_cursor = (pr_cursor <= 8'd1) ? len : pr_cursor - 8'd1;
            o.menu_value = pr_cursor;
          end
          kslp_pkg::KEY_DOWN: begin
            pr_cursor = (pr_cursor >= len) ? 8'd1 : pr_cursor + 8'd1;
            o.menu_value = pr_cursor;
          end
          kslp_pkg::KEY_OK: begin
            pr_cursor = 8'd1;
            o.menu_value = '0;
          end
          default: o.menu_value = pr_cursor;
        endcase
      end
      default: ;
    endcase
    if (o.key_code == kslp_pkg::KEY_LONG) long_keys++;
    return o;
  endfunction

  task automatic push_req(input kslp_pkg::req_t r, input logic fixed,
                          input kslp_pkg::rsp_t want);
    kslp_pkg::rsp_t pred;
    while ($urandom_range(0, 99) < req_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pred = predict_scan(r);
    awaited_rsp.push_back(fixed ? want : pred);
    sent++;
  endtask

  task automatic send_tick(input logic up, input logic dn, input logic ok);
    kslp_pkg::req_t r;
    r.action      = kslp_pkg::ACT_TICK;
    r.up_level    = up;
    r.down_level  = dn;
    r.ok_level    = ok;
    r.menu_length = 8'($urandom);
    push_req(r, 1'b0, '0);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kslp_pkg::CfgIdxW-1:0] idx,
                           input logic [kslp_pkg::CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    if (idx == kslp_pkg::CFG_SAMPLE_INTERVAL) pr_interval = val[kslp_pkg::IntW-1:0];
    else if (idx == kslp_pkg::CFG_LONG_PRESS) pr_long = val;
  endtask

  task automatic set_config(input logic [kslp_pkg::IntW-1:0] iv,
                            input logic [kslp_pkg::HoldW-1:0] lp,
                            input logic spare);
    drain();
    write_reg(kslp_pkg::CFG_SAMPLE_INTERVAL, {8'($urandom), iv});
    write_reg(kslp_pkg::CFG_LONG_PRESS, lp);
    if (spare) begin
      write_reg(CfgIdxSpareA, 16'($urandom));
      write_reg(CfgIdxSpareB, 16'($urandom));
    end
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // press, hold, release, then read back; some raw noise in between
  task automatic run_gestures(input int budget);
    int start;
    int iv;
    int n;
    int kind;
    logic up, dn, ok;
    kslp_pkg::req_t r;
    start = sent;
    iv = (pr_interval == '0) ? 1 : int'(pr_interval);
    while (sent - start < budget) begin
      if ($urandom_range(0, 99) < 15) begin
        r.action      = 2'($urandom_range(0, 3));
        r.up_level    = 1'($urandom);
        r.down_level  = 1'($urandom);
        r.ok_level    = 1'($urandom);
        r.menu_length = 8'($urandom);
        push_req(r, 1'b0, '0);
      end else begin
        kind = $urandom_range(0, 4);
        {up, dn, ok} = 3'b111;
        n = $urandom_range(1, 3 * iv + 1);
        case (kind)
          0: up = 1'b0;
          1: dn = 1'b0;
          2: ok = 1'b0;
          3: begin
            ok = 1'b0;
            if (pr_long < 16'd4000) n = int'(pr_long) + $urandom_range(iv, 3 * iv);
          end
          default: {up, dn, ok} = 3'($urandom);
        endcase
        repeat (n) begin
          if ($urandom_range(0, 99) < 5) send_tick(1'($urandom), 1'($urandom), 1'($urandom));
          else send_tick(up, dn, ok);
        end
        repeat ($urandom_range(1, 2 * iv + 1)) send_tick(1'b1, 1'b1, 1'b1);
        repeat ($urandom_range(1, 2)) begin
          r.action      = ($urandom_range(0, 9) < 7) ? kslp_pkg::ACT_MENU : kslp_pkg::ACT_TAKE;
          r.up_level    = 1'($urandom);
          r.down_level  = 1'($urandom);
          r.ok_level    = 1'($urandom);
          r.menu_length = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 12)) : 8'($urandom);
          push_req(r, 1'b0, '0);
        end
      end
    end
  endtask

  // result checker
  initial begin
    kslp_pkg::rsp_t want;
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: key_code %0d menu_value %0d",
                     rsp_if.data.key_code, rsp_if.data.menu_value);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp_if.data.key_code !== want.key_code ||
              rsp_if.data.menu_value !== want.menu_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: key_code exp %0d got %0d, menu_value exp %0d got %0d",
                       want.key_code, rsp_if.data.key_code,
                       want.menu_value, rsp_if.data.menu_value);
          end
        end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
    end
  end

  // stimulus
  initial begin
    kslp_pkg::req_t r;
    kslp_pkg::rsp_t want;
    int   dir_count;
    rst_ni       <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data  <= '0;
    pr_interval = kslp_pkg::SampleIntervalRst;
    pr_long     = kslp_pkg::LongPressRst;
    pr_div      = '0;
    pr_hold     = '0;
    pr_prior    = kslp_pkg::KEY_NONE;
    pr_code     = kslp_pkg::KEY_NONE;
    pr_latched  = kslp_pkg::KEY_NONE;
    pr_cursor   = 8'd1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      if (i == ResetRows) set_config(8'd1, 16'd2, 1'b0);
      r.action      = DirRows[i].act;
      r.up_level    = DirRows[i].up;
      r.down_level  = DirRows[i].dn;
      r.ok_level    = DirRows[i].ok;
      r.menu_length = DirRows[i].len;
      want.key_code   = DirRows[i].key;
      want.menu_value = DirRows[i].val;
      push_req(r, DirRows[i].fixed, want);
    end
    dir_count = sent;

    run_gestures(230);
    set_config(8'd0, 16'd0, 1'b1);
    run_gestures(180);
    req_gap_pct   = 0;
    rsp_stall_pct = 0;
    set_config(8'd3, 16'd12, 1'b0);
    run_gestures(180);
    req_gap_pct   = 29;
    rsp_stall_pct = 29;
    set_config(8'd2, 16'hFFFF, 1'b0);
    run_gestures(130);
    set_config(kslp_pkg::SampleIntervalRst, 16'd60, 1'b0);
    run_gestures(200);
    set_config(8'd12, 16'd5, 1'b0);
    run_gestures(200);

    drain();
    repeat (6) @(posedge clk_i);
    $display("Ran %0d requests (%0d directed) over %0d register settings", sent, dir_count,
             settings);
    $display("Predicted %0d long-press keys and %0d menu steps; %0d mismatches", long_keys,
             menu_steps, mismatches);
    if (mismatches == 0 && awaited_rsp.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
